// ===== src/ueds_pkg.sv =====
package ueds_pkg;

   // Operation codes carried in the request.
   localparam logic [1:0] OP_MARK   = 2'd0;
   localparam logic [1:0] OP_EDGE   = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   // Field widths fixed by the stream format.
   localparam int NODE_W    = 10;
   localparam int COVERED_W = 16;
   localparam int LIVE_W    = 11;
   localparam int PAIR_W    = 32;
   localparam int DEGREE_W  = 16;
   // Wide enough to hold any node count the design supports.
   localparam int NODE_EXT_W = 17;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // Command kinds after classification in the front end.
   typedef enum logic [1:0] {
      CMD_MARK,
      CMD_EDGE,
      CMD_REPORT,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WB
   } back_state_type;

   // One result transaction.
   typedef struct packed {
      logic                 edge_uncovered;
      logic [PAIR_W-1:0]    pair_count;
      logic [LIVE_W-1:0]    live_nodes;
      logic [COVERED_W-1:0] covered_edges;
   } result_type;

   function automatic logic [COVERED_W-1:0] sat_inc_covered(input logic [COVERED_W-1:0] v);
      sat_inc_covered = (v == {COVERED_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [LIVE_W-1:0] sat_inc_live(input logic [LIVE_W-1:0] v);
      sat_inc_live = (v == {LIVE_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [DEGREE_W-1:0] sat_inc_degree(input logic [DEGREE_W-1:0] v);
      sat_inc_degree = (v == {DEGREE_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [PAIR_W-1:0] sat_add_pair(input logic [PAIR_W-1:0] p,
                                                      input logic [DEGREE_W-1:0] d);
      logic [PAIR_W:0] sum;
      sum = {1'b0, p} + {{(PAIR_W + 1 - DEGREE_W){1'b0}}, d};
      sat_add_pair = sum[PAIR_W] ? {PAIR_W{1'b1}} : sum[PAIR_W-1:0];
   endfunction

endpackage

// ===== src/ueds_ram.sv =====
module ueds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   // One write port and two registered read ports; read data holds while re is low.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd0_ff <= mem_ff[raddr0];
         rd1_ff <= mem_ff[raddr1];
      end
   end

   assign rdata0 = rd0_ff;
   assign rdata1 = rd1_ff;

endmodule

// ===== src/ueds_front.sv =====
module ueds_front #(
   parameter int MAX_NODES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ueds_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                pop,
   output logic                                head_valid,
   output ueds_pkg::cmd_type                   head_cmd
);
   import ueds_pkg::*;

   localparam logic [NODE_EXT_W-1:0] NODE_LIMIT = NODE_EXT_W'(MAX_NODES);

   logic [1:0]        op;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;
   logic              a_ok;
   logic              b_ok;
   cmd_type           cmd;
   logic              push;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign op     = req_tdata[1:0];
   assign node_a = req_tdata[11:2];
   assign node_b = req_tdata[21:12];

   // Classify the transaction; anything that cannot change state becomes a no-op.
   always_comb begin
      a_ok = {{(NODE_EXT_W - NODE_W){1'b0}}, node_a} < NODE_LIMIT;
      b_ok = {{(NODE_EXT_W - NODE_W){1'b0}}, node_b} < NODE_LIMIT;
      cmd.node_a = node_a;
      cmd.node_b = node_b;
      case (op)
         OP_MARK:   cmd.kind = a_ok ? CMD_MARK : CMD_NOP;
         OP_EDGE:   cmd.kind = (a_ok && b_ok) ? CMD_EDGE : CMD_NOP;
         OP_REPORT: cmd.kind = CMD_REPORT;
         default:   cmd.kind = CMD_NOP;
      endcase
   end

   // Two-entry queue towards the back end.
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== src/ueds_back.sv =====
module ueds_back #(
   parameter int MAX_NODES = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  ueds_pkg::cmd_type       head_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ueds_pkg::result_type    rsp_result
);
   import ueds_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);
   localparam int DW = DEGREE_W + 1;

   back_state_type state_ff;
   back_state_type state_in;

   logic [AW-1:0]        clr_cnt_ff;
   logic [AW-1:0]        clr_cnt_in;
   logic [AW-1:0]        a_ff;
   logic [AW-1:0]        a_in;
   logic [AW-1:0]        b_ff;
   logic [AW-1:0]        b_in;
   logic [COVERED_W-1:0] covered_ff;
   logic [COVERED_W-1:0] covered_in;
   logic [LIVE_W-1:0]    live_ff;
   logic [LIVE_W-1:0]    live_in;
   logic [PAIR_W-1:0]    pair_ff;
   logic [PAIR_W-1:0]    pair_in;
   logic [DEGREE_W-1:0]  deg_a_new_ff;
   logic [DEGREE_W-1:0]  deg_a_new_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_result_ff;
   result_type           rsp_result_in;

   logic [NODE_EXT_W-1:0] head_a_ext;
   logic [NODE_EXT_W-1:0] head_b_ext;
   logic [AW-1:0]         head_a;
   logic [AW-1:0]         head_b;
   logic                  out_free;
   logic                  load_rsp;
   logic                  same_node;

   // Memory ports.
   logic          cov_we;
   logic [AW-1:0] cov_waddr;
   logic          cov_wdata;
   logic          deg_we;
   logic [AW-1:0] deg_waddr;
   logic [DW-1:0] deg_wdata;
   logic          mem_re;
   logic          cov_rd_a;
   logic          cov_rd_b;
   logic [DW-1:0] deg_rd_a;
   logic [DW-1:0] deg_rd_b;
   logic [DEGREE_W-1:0] deg_b_cur;
   logic                touch_b_cur;

   assign head_a_ext = {{(NODE_EXT_W - NODE_W){1'b0}}, head_cmd.node_a};
   assign head_b_ext = {{(NODE_EXT_W - NODE_W){1'b0}}, head_cmd.node_b};
   assign head_a     = head_a_ext[AW-1:0];
   assign head_b     = head_b_ext[AW-1:0];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign same_node  = (a_ff == b_ff);

   // Covered bit for each node.
   ueds_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_cov_ram (
      .clock  (clock),
      .we     (cov_we),
      .waddr  (cov_waddr),
      .wdata  (cov_wdata),
      .re     (mem_re),
      .raddr0 (head_a),
      .raddr1 (head_b),
      .rdata0 (cov_rd_a),
      .rdata1 (cov_rd_b)
   );

   // Touched bit and degree for each node, touched in the top bit.
   ueds_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock  (clock),
      .we     (deg_we),
      .waddr  (deg_waddr),
      .wdata  (deg_wdata),
      .re     (mem_re),
      .raddr0 (head_a),
      .raddr1 (head_b),
      .rdata0 (deg_rd_a),
      .rdata1 (deg_rd_b)
   );

   // A self-loop sees the degree left by its first endpoint.
   assign deg_b_cur   = same_node ? deg_a_new_ff : deg_rd_b[DEGREE_W-1:0];
   assign touch_b_cur = same_node ? 1'b1 : deg_rd_b[DEGREE_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.kind)
                  CMD_EDGE:   state_in = ST_EXEC;
                  CMD_REPORT: state_in = out_free ? ST_CLEAR : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXEC: begin
            if (cov_rd_a || cov_rd_b) begin
               state_in = out_free ? ST_IDLE : ST_EXEC;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            state_in = out_free ? ST_IDLE : ST_WB;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and memory control for each state.
   always_comb begin
      pop          = 1'b0;
      mem_re       = 1'b0;
      cov_we       = 1'b0;
      cov_waddr    = a_ff;
      cov_wdata    = 1'b0;
      deg_we       = 1'b0;
      deg_waddr    = a_ff;
      deg_wdata    = '0;
      load_rsp     = 1'b0;
      clr_cnt_in   = clr_cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      covered_in   = covered_ff;
      live_in      = live_ff;
      pair_in      = pair_ff;
      deg_a_new_in = deg_a_new_ff;
      rsp_result_in.covered_edges  = covered_ff;
      rsp_result_in.live_nodes     = live_ff;
      rsp_result_in.pair_count     = pair_ff;
      rsp_result_in.edge_uncovered = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep both memories back to zero, one entry a cycle.
            cov_we     = 1'b1;
            cov_waddr  = clr_cnt_ff;
            deg_we     = 1'b1;
            deg_waddr  = clr_cnt_ff;
            clr_cnt_in = (clr_cnt_ff == LAST_IDX) ? '0 : clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.kind)
                  CMD_EDGE: begin
                     pop    = 1'b1;
                     mem_re = 1'b1;
                     a_in   = head_a;
                     b_in   = head_b;
                  end
                  CMD_MARK: begin
                     if (out_free) begin
                        pop       = 1'b1;
                        load_rsp  = 1'b1;
                        cov_we    = 1'b1;
                        cov_waddr = head_a;
                        cov_wdata = 1'b1;
                     end
                  end
                  CMD_REPORT: begin
                     // Report the totals from before the clear.
                     if (out_free) begin
                        pop        = 1'b1;
                        load_rsp   = 1'b1;
                        covered_in = '0;
                        live_in    = '0;
                        pair_in    = '0;
                        clr_cnt_in = '0;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        pop      = 1'b1;
                        load_rsp = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (cov_rd_a || cov_rd_b) begin
               if (out_free) begin
                  load_rsp   = 1'b1;
                  covered_in = sat_inc_covered(covered_ff);
                  rsp_result_in.covered_edges = covered_in;
               end
            end else begin
               // First endpoint: add its degree, then bump it.
               deg_a_new_in = sat_inc_degree(deg_rd_a[DEGREE_W-1:0]);
               deg_we       = 1'b1;
               deg_waddr    = a_ff;
               deg_wdata    = {1'b1, deg_a_new_in};
               live_in      = deg_rd_a[DEGREE_W] ? live_ff : sat_inc_live(live_ff);
               pair_in      = sat_add_pair(pair_ff, deg_rd_a[DEGREE_W-1:0]);
            end
         end
         ST_WB: begin
            // Second endpoint, then the result.
            if (out_free) begin
               load_rsp  = 1'b1;
               deg_we    = 1'b1;
               deg_waddr = b_ff;
               deg_wdata = {1'b1, sat_inc_degree(deg_b_cur)};
               live_in   = touch_b_cur ? live_ff : sat_inc_live(live_ff);
               pair_in   = sat_add_pair(pair_ff, deg_b_cur);
               rsp_result_in.live_nodes     = live_in;
               rsp_result_in.pair_count     = pair_in;
               rsp_result_in.edge_uncovered = 1'b1;
            end
         end
         default: begin
            clr_cnt_in = '0;
         end
      endcase
   end

   // Output register: holds a result until the sink takes it.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         covered_ff   <= '0;
         live_ff      <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         covered_ff   <= covered_in;
         live_ff      <= live_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      deg_a_new_ff <= deg_a_new_in;
      if (load_rsp) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// ===== src/uncovered_edge_degree_stats.sv =====
// Channel   Direction  Transaction
// req_      in         one command: mark node, process edge, report and clear
// rsp_      out        one result per command: running totals and edge flag
//
// Marks, no-ops and reports are handled in the idle state; a report then sweeps
// all MAX_NODES entries to clear the node memories. An edge passes the execute
// state, then the write-back state if it touches no covered node, for the degree
// memory's read-modify-write. After reset the same sweep runs before any command.
// A two-entry queue and an output register let input and output stall apart.
module uncovered_edge_degree_stats #(
   parameter int MAX_NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op [1:0], node_a [11:2], node_b [21:12], zero [23:22]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // covered_edges [15:0], live_nodes [26:16], pair_count [58:27],
   // edge_uncovered [59], zero [63:60]
   output logic [63:0] rsp_tdata
);
   import ueds_pkg::*;

   logic       pop;
   logic       head_valid;
   cmd_type    head_cmd;
   result_type result;

   ueds_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ueds_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the result fields, highest field first.
   assign rsp_tdata = {4'd0, result.edge_uncovered, result.pair_count,
                       result.live_nodes, result.covered_edges};

endmodule

// ===== bench/uncovered_edge_degree_stats_tb.sv =====
module uncovered_edge_degree_stats_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ueds_pkg::*;

   // The fourth operation code has no meaning and must leave the totals alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NODE_COUNT     = 1024;
   localparam int RANDOM_ITEMS   = 800;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_LIMIT    = 100000;

   // One row of the directed table; the totals apply only where typed is set.
   typedef struct packed {
      logic [1:0]           op;
      logic [NODE_W-1:0]    node_a;
      logic [NODE_W-1:0]    node_b;
      logic                 typed;
      logic [COVERED_W-1:0] covered;
      logic [LIVE_W-1:0]    live;
      logic [PAIR_W-1:0]    pairs;
      logic                 uncovered;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // op [1:0], node_a [11:2], node_b [21:12], zero [23:22]
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // covered_edges [15:0], live_nodes [26:16], pair_count [58:27],
   // edge_uncovered [59], zero [63:60]
   logic [63:0] rsp_tdata;

   // Shadow copy of the graph state.
   bit                   covered_bits [NODE_COUNT];
   bit                   seen_bits [NODE_COUNT];
   logic [DEGREE_W-1:0]  node_degree [NODE_COUNT];
   logic [COVERED_W-1:0] covered_count;
   logic [LIVE_W-1:0]    live_count;
   logic [PAIR_W-1:0]    pair_sum;

   result_type awaited_totals [$];
   int fail_count    = 0;
   int commands_sent = 0;
   int tx_mode       = 0;
   int rx_mode       = 0;
   bit rx_hold       = 1'b0;

   uncovered_edge_degree_stats dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Generous ceiling on the whole run.
   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void clear_graph();
      for (int n = 0; n < NODE_COUNT; n++) begin
         covered_bits[n] = 1'b0;
         seen_bits[n]    = 1'b0;
         node_degree[n]  = '0;
      end
      covered_count = '0;
      live_count    = '0;
      pair_sum      = '0;
   endfunction

   // One endpoint of a live edge: first touch counts the node, then its degree so
   // far joins the pair sum before the degree itself goes up.
   function automatic void visit_node(logic [NODE_W-1:0] n);
      logic [PAIR_W:0] widened;
      if (!seen_bits[n]) begin
         seen_bits[n] = 1'b1;
         if (live_count != {LIVE_W{1'b1}})
            live_count = live_count + 1'b1;
      end
      widened  = {1'b0, pair_sum} + {{(PAIR_W + 1 - DEGREE_W){1'b0}}, node_degree[n]};
      pair_sum = widened[PAIR_W] ? {PAIR_W{1'b1}} : widened[PAIR_W-1:0];
      if (node_degree[n] != {DEGREE_W{1'b1}})
         node_degree[n] = node_degree[n] + 1'b1;
   endfunction

   // Applies one command to the shadow graph and returns the totals it answers with.
   // A report answers with the totals from before the clear.
   function automatic result_type apply_to_graph(logic [1:0] op, logic [NODE_W-1:0] a,
                                                 logic [NODE_W-1:0] b);
      result_type totals;
      totals.edge_uncovered = 1'b0;
      if (op == OP_MARK) begin
         covered_bits[a] = 1'b1;
      end else if (op == OP_EDGE) begin
         if (covered_bits[a] || covered_bits[b]) begin
            if (covered_count != {COVERED_W{1'b1}})
               covered_count = covered_count + 1'b1;
         end else begin
            visit_node(a);
            visit_node(b);
            totals.edge_uncovered = 1'b1;
         end
      end
      totals.covered_edges = covered_count;
      totals.live_nodes    = live_count;
      totals.pair_count    = pair_sum;
      if (op == OP_REPORT)
         clear_graph();
      return totals;
   endfunction

   // Sender gaps: mode 0 never idles, mode 1 idles briefly, mode 2 adds long pauses.
   function automatic int pick_gap(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0 || roll < 60)
         return 0;
      if (roll < 95 || mode == 1)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_stall(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0 || roll < 55)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return (mode == 1) ? $urandom_range(4, 8) : $urandom_range(15, 50);
   endfunction

   // Offers one command, waits for its transaction and records what it should answer.
   // Called just after a rising edge; valid stays high when the next command follows.
   task automatic send_command(logic [1:0] op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                               bit typed, result_type typed_totals);
      result_type predicted;
      result_type expected;
      int gap;
      req_tdata  <= {2'b00, b, a, op};
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      predicted = apply_to_graph(op, a, b);
      expected  = typed ? typed_totals : predicted;
      awaited_totals = {awaited_totals, expected};
      commands_sent++;
      gap = pick_gap(tx_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send(logic [1:0] op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      send_command(op, a, b, 1'b0, '0);
   endtask

   // Sender pause: nothing more is offered until every result is back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (awaited_totals.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [NODE_W-1:0] pool_node(int base, int span);
      return NODE_W'((base + $urandom_range(0, span - 1)) % NODE_COUNT);
   endfunction

   // A graph session: a few marks first, then mostly edges over a node pool, with
   // late marks, unused codes, stray nodes and the odd mid-session report as noise.
   task automatic play_session(int length);
      int base;
      int span;
      int roll;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      base = $urandom_range(0, NODE_COUNT - 1);
      span = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 24) : $urandom_range(64, 1024);
      repeat ($urandom_range(0, 4))
         send(OP_MARK, pool_node(base, span), NODE_W'($urandom));
      repeat (length) begin
         roll = $urandom_range(0, 99);
         a = pool_node(base, span);
         b = pool_node(base, span);
         if (roll < 70)
            send(OP_EDGE, a, b);
         else if (roll < 76)
            send(OP_EDGE, a, a);
         else if (roll < 83)
            send(OP_MARK, a, b);
         else if (roll < 88)
            send(OP_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
         else if (roll < 95)
            send(OP_EDGE, NODE_W'($urandom), NODE_W'($urandom));
         else if (roll < 97)
            send(OP_REPORT, a, b);
         else
            send(OP_MARK, NODE_W'($urandom), b);
      end
      if ($urandom_range(0, 9) < 8)
         send(OP_REPORT, NODE_W'($urandom), NODE_W'($urandom));
   endtask

   // Result side back-pressure, with one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_stall(rx_mode);
         end
      end
   end

   // Every result transaction is matched with the oldest outstanding command.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[59:0]);
         if (awaited_totals.size() == 0) begin
            $error("result transaction with no command outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = awaited_totals.pop_front();
            bad  = 1'b0;
            if (got.covered_edges !== want.covered_edges) begin
               bad = 1'b1;
               $error("covered_edges: expected %0d, got %0d",
                      want.covered_edges, got.covered_edges);
            end
            if (got.live_nodes !== want.live_nodes) begin
               bad = 1'b1;
               $error("live_nodes: expected %0d, got %0d", want.live_nodes, got.live_nodes);
            end
            if (got.pair_count !== want.pair_count) begin
               bad = 1'b1;
               $error("pair_count: expected %0d, got %0d", want.pair_count, got.pair_count);
            end
            if (got.edge_uncovered !== want.edge_uncovered) begin
               bad = 1'b1;
               $error("edge_uncovered: expected %0d, got %0d",
                      want.edge_uncovered, got.edge_uncovered);
            end
            if (rsp_tdata[63:60] !== 4'd0) begin
               bad = 1'b1;
               $error("padding: expected 0, got %h", rsp_tdata[63:60]);
            end
            if (bad)
               fail_count++;
         end
      end
   end

   initial begin
      step_row_type rows [0:22];
      result_type typed_totals;
      int session_no;
      int waited;

      clear_graph();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: reset state, unused code, self-loops, marks before and after
      // edges, repeated marks, report and clear, and alternating node bit patterns.
      rows = '{
         '{OP_REPORT, 0,     0,     1, 0, 0, 0, 0},
         '{OP_UNUSED, 1023,  1023,  1, 0, 0, 0, 0},
         '{OP_EDGE,   0,     1023,  1, 0, 2, 0, 1},
         '{OP_EDGE,   0,     1023,  1, 0, 2, 2, 1},
         '{OP_EDGE,   5,     5,     1, 0, 3, 3, 1},
         '{OP_MARK,   1023,  0,     1, 0, 3, 3, 0},
         '{OP_EDGE,   1023,  7,     1, 1, 3, 3, 0},
         '{OP_EDGE,   7,     1023,  1, 2, 3, 3, 0},
         '{OP_MARK,   0,     1023,  1, 2, 3, 3, 0},
         '{OP_EDGE,   0,     0,     1, 3, 3, 3, 0},
         '{OP_EDGE,   5,     6,     0, 0, 0, 0, 0},
         '{OP_UNUSED, 512,   341,   1, 3, 4, 5, 0},
         '{OP_MARK,   1,     0,     1, 3, 4, 5, 0},
         '{OP_MARK,   1,     1023,  1, 3, 4, 5, 0},
         '{OP_EDGE,   1,     2,     1, 4, 4, 5, 0},
         '{OP_EDGE,   2,     3,     0, 0, 0, 0, 0},
         '{OP_REPORT, 1023,  1023,  1, 4, 6, 5, 0},
         '{OP_EDGE,   0,     1023,  1, 0, 2, 0, 1},
         '{OP_EDGE,   'h2AA, 'h155, 1, 0, 4, 0, 1},
         '{OP_EDGE,   'h155, 'h2AA, 1, 0, 4, 2, 1},
         '{OP_MARK,   'h2AA, 'h155, 1, 0, 4, 2, 0},
         '{OP_EDGE,   'h2AA, 'h155, 1, 1, 4, 2, 0},
         '{OP_REPORT, 'h155, 'h2AA, 1, 1, 4, 2, 0}
      };
      tx_mode = 1;
      rx_mode = 1;
      foreach (rows[i]) begin
         typed_totals.covered_edges  = rows[i].covered;
         typed_totals.live_nodes     = rows[i].live;
         typed_totals.pair_count     = rows[i].pairs;
         typed_totals.edge_uncovered = rows[i].uncovered;
         send_command(rows[i].op, rows[i].node_a, rows[i].node_b, rows[i].typed, typed_totals);
      end

      // Random sessions with varied idling on both sides.
      session_no = 0;
      while (commands_sent < RANDOM_ITEMS + $size(rows)) begin
         tx_mode = $urandom_range(0, 2);
         rx_mode = $urandom_range(0, 2);
         if (session_no == 2) begin
            // Results held back while commands keep coming, so the input backs up.
            tx_mode = 0;
            rx_hold = 1'b1;
         end
         if (session_no == 4)
            wait_for_results();
         play_session($urandom_range(40, 150));
         session_no++;
      end

      // Every node live, so the live count reaches its largest value, with no
      // idling on either side.
      wait_for_results();
      tx_mode = 0;
      rx_mode = 0;
      send(OP_REPORT, 0, 0);
      for (int n = 0; n < NODE_COUNT; n += 2)
         send(OP_EDGE, NODE_W'(n), NODE_W'(n + 1));
      send(OP_REPORT, 0, 0);

      // Drain, then allow a little longer for any stray result.
      req_tvalid <= 1'b0;
      rx_mode = 1;
      for (waited = 0; waited < DRAIN_LIMIT && awaited_totals.size() != 0; waited++)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (awaited_totals.size() != 0) begin
         $error("%0d result transactions never arrived", awaited_totals.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
